// File: src/memory_region_table_search_unit_assert.svh
// assertion macros for the memory region table search unit
`ifndef MEMORY_REGION_TABLE_SEARCH_UNIT_ASSERT_SVH
`define MEMORY_REGION_TABLE_SEARCH_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define MRTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define MRTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/mrts_pkg.sv
// shared types and constants of the memory region table search unit
`default_nettype none

package mrts_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 64;
  localparam int unsigned TYPE_BITS_DEF   = 3;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned ADDR_W   = 64;
  localparam int unsigned LEN_W    = 64;
  localparam int unsigned RTYPE_W  = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned INDEX_W  = 6;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned CAP_W      = 7;

  localparam logic [MODE_W-1:0] MODE_ADD       = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FIND_LEN  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FIND_HIGH = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_USABLE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECLAIM  = 2'd2;

  localparam logic [CAP_W-1:0]   CAPACITY_RST = 7'd0;
  localparam logic [RTYPE_W-1:0] USABLE_RST   = 3'd0;
  localparam logic [RTYPE_W-1:0] RECLAIM_RST  = 3'd5;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [ADDR_W-1:0]  region_base;
    logic [LEN_W-1:0]   region_length;
    logic [RTYPE_W-1:0] region_type;
  } mrts_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  entry_index;
    logic [ADDR_W-1:0]   entry_base;
    logic [LEN_W-1:0]    entry_length;
    logic [RTYPE_W-1:0]  entry_type;
  } mrts_out_t;

  localparam mrts_out_t RESULT_NOT_FOUND = '{
    status:       STATUS_NOT_FOUND,
    entry_index:  '0,
    entry_base:   '0,
    entry_length: '0,
    entry_type:   '0
  };

  localparam mrts_out_t RESULT_OVERFLOW = '{
    status:       STATUS_OVERFLOW,
    entry_index:  '0,
    entry_base:   '0,
    entry_length: '0,
    entry_type:   '0
  };

endpackage

`default_nettype wire

// File: src/mrts_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module mrts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: src/memory_region_table_search_unit.sv
// memory region table search unit: region store, add and two scan searches
// channels: in (valid/ready, mrts_in_t) carries one command transaction,
//   out (valid/ready, mrts_out_t) returns exactly one result per command,
//   cfg is a plain write port (capacity, usable type, reclaimable type)
// add: appends base/length/type at index entry_count, or answers overflow
//   when entry_count has reached capacity or MAX_ENTRIES; the result is
//   registered in res_q and then moves into the output register
// find-at-least / find-highest: the region ram is scanned one entry per
//   cycle through a single 64-bit magnitude comparator, paced by the ram's
//   one read port; the scan ends early on the first length hit, otherwise
//   it reads every stored entry; the result passes through res_q into the
//   output register, and the next command can be taken once the sequencer
//   is back in idle
// in_ready_o is high only while the sequencer is idle; a finished result
//   moves into the output register as soon as that register is free, so the
//   next command may be accepted while the previous result still waits
// receiver stall: the output register holds its transaction, and the block
//   stalls in its response state once it has a second result ready
// reset: entry_count clears, config returns to capacity 0, usable 0,
//   reclaimable 5; the region ram is not cleared, only entries below count are read
`default_nettype none

`include "memory_region_table_search_unit_assert.svh"

module memory_region_table_search_unit
  import mrts_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int unsigned TYPE_BITS   = TYPE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire mrts_in_t              in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output mrts_out_t                  out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW   = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMPW = (CW > CAP_W) ? CW : CAP_W;
  localparam int unsigned EW   = ADDR_W + LEN_W + TYPE_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  // configuration registers
  logic [CAP_W-1:0]   cap_q;
  logic [RTYPE_W-1:0] usable_q;
  logic [RTYPE_W-1:0] reclaim_q;

  // sequencer and scan state
  logic [1:0]        state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     issue_q, issue_d;
  logic              rvalid_q, rvalid_d;
  logic [AW-1:0]     ridx_q, ridx_d;
  logic [MODE_W-1:0] mode_q, mode_d;
  logic [LEN_W-1:0]  req_len_q, req_len_d;
  mrts_out_t         res_q, res_d;

  // output register
  logic      out_valid_q, out_valid_d;
  mrts_out_t out_q, out_d;

  // ram side
  logic              ram_we;
  logic [EW-1:0]     ram_wdata;
  logic [EW-1:0]     ram_rdata;
  logic [ADDR_W-1:0] rd_base;
  logic [LEN_W-1:0]  rd_len;
  logic [TYPE_BITS-1:0] rd_type;
  logic [TYPE_BITS-1:0] in_type;

  // shared comparator
  logic [ADDR_W-1:0] op_a, op_b;
  logic              cmp_ge, cmp_eq, type_ok, hit;

  logic in_fire, room, out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // room for one more entry: below both the configured and the built capacity
  assign room = (CMPW'(count_q) < CMPW'(cap_q)) && (count_q < CW'(MAX_ENTRIES));

  assign in_type   = TYPE_BITS'(in_data_i.region_type);
  assign ram_we    = in_fire && (in_data_i.mode == MODE_ADD) && room;
  assign ram_wdata = {in_data_i.region_base, in_data_i.region_length, in_type};

  mrts_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (issue_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign rd_base = ram_rdata[EW-1 -: ADDR_W];
  assign rd_len  = ram_rdata[TYPE_BITS +: LEN_W];
  assign rd_type = ram_rdata[TYPE_BITS-1:0];

  // one magnitude compare serves both searches; best base lives in res_q
  assign op_a    = (mode_q == MODE_FIND_LEN) ? rd_len : rd_base;
  assign op_b    = (mode_q == MODE_FIND_LEN) ? req_len_q : res_q.entry_base;
  assign cmp_ge  = (op_a >= op_b);
  assign cmp_eq  = (op_a == op_b);
  assign type_ok = (rd_type == TYPE_BITS'(usable_q)) || (rd_type == TYPE_BITS'(reclaim_q));
  assign hit     = (mode_q == MODE_FIND_LEN) ? cmp_ge : (cmp_ge && !cmp_eq && type_ok);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    issue_d   = issue_q;
    rvalid_d  = 1'b0;
    ridx_d    = ridx_q;
    mode_d    = mode_q;
    req_len_d = req_len_q;
    res_d     = res_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          mode_d    = in_data_i.mode;
          req_len_d = in_data_i.region_length;
          issue_d   = '0;
          res_d     = RESULT_NOT_FOUND;
          case (in_data_i.mode) inside
            MODE_ADD: begin
              state_d = S_RESP;
              if (room) begin
                count_d            = count_q + 1'b1;
                res_d.status       = STATUS_OK;
                res_d.entry_index  = INDEX_W'(count_q);
                res_d.entry_base   = in_data_i.region_base;
                res_d.entry_length = in_data_i.region_length;
                res_d.entry_type   = RTYPE_W'(in_type);
              end else begin
                res_d = RESULT_OVERFLOW;
              end
            end
            MODE_FIND_LEN, MODE_FIND_HIGH: begin
              state_d = S_SCAN;
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_SCAN: begin
        // issue the next read while the previous entry is compared
        if (issue_q != count_q) begin
          issue_d  = issue_q + 1'b1;
          rvalid_d = 1'b1;
          ridx_d   = issue_q[AW-1:0];
        end
        if (rvalid_q && hit) begin
          res_d.status       = STATUS_OK;
          res_d.entry_index  = INDEX_W'(ridx_q);
          res_d.entry_base   = rd_base;
          res_d.entry_length = rd_len;
          res_d.entry_type   = RTYPE_W'(rd_type);
        end
        // first length match ends the scan, otherwise run to the last entry
        if ((rvalid_q && hit && (mode_q == MODE_FIND_LEN)) || (issue_q == count_q)) begin
          state_d  = S_RESP;
          rvalid_d = 1'b0;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if ((state_q == S_RESP) && out_free) begin
      out_d       = res_q;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAPACITY_RST;
      usable_q    <= USABLE_RST;
      reclaim_q   <= RECLAIM_RST;
      state_q     <= S_IDLE;
      count_q     <= '0;
      issue_q     <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_CAPACITY: cap_q     <= cfg_data_i;
          CFG_USABLE:   usable_q  <= RTYPE_W'(cfg_data_i);
          CFG_RECLAIM:  reclaim_q <= RTYPE_W'(cfg_data_i);
          default: ;
        endcase
      end
      state_q     <= state_d;
      count_q     <= count_d;
      issue_q     <= issue_d;
      rvalid_q    <= rvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ridx_q    <= ridx_d;
    mode_q    <= mode_d;
    req_len_q <= req_len_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  `MRTS_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(MAX_ENTRIES), "entry count above table size")
  `MRTS_ASSERT_IMP(a_issue_bound, state_q == S_SCAN, issue_q <= count_q, "scan read past last entry")
  `MRTS_ASSERT_IMP(a_rvalid_scan, rvalid_q, state_q == S_SCAN, "read data pending outside scan")
  `MRTS_ASSERT_NXT(a_add_count, ram_we, count_q == $past(count_q) + 1'b1, "add did not bump count")
  `MRTS_ASSERT_NXT(a_resp_load, (state_q == S_RESP) && out_free, out_valid_o && (state_q == S_IDLE),
                   "result not moved to output register")

endmodule

`default_nettype wire
